@@ hdl/hcp_pkg.sv @@
// Shared constants and types for the Hermite curve point pipeline.
package hcp_pkg;

  localparam int T_FRAC_BITS_DEF = 16;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int CFG_INDEX_WIDTH = 4;
  localparam int NUM_TERMS       = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_X     = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_Y     = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_X       = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_Y       = 4'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TAN_X = 4'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TAN_Y = 4'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_TAN_X   = 4'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_TAN_Y   = 4'd7;

  // basis term slots: start point, end point, start tangent, end tangent
  localparam int TERM_START     = 0;
  localparam int TERM_END       = 1;
  localparam int TERM_START_TAN = 2;
  localparam int TERM_END_TAN   = 3;

  // pipeline stages
  localparam int ST_SQUARE = 0;
  localparam int ST_CUBE   = 1;
  localparam int ST_WEIGHT = 2;
  localparam int ST_PROD   = 3;
  localparam int ST_SUM    = 4;
  localparam int ST_OUT    = 5;
  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

@@ hdl/hcp_ctrl.sv @@
// Valid tracking and per-stage load enables for the curve pipeline.
module hcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hcp_pkg::pipe_ctrl_t ctrl
);
  import hcp_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] feed;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !valid[i] || rdy[i+1];
    end
  end

  assign feed      = {valid[NUM_STAGES-2:0], in_valid};
  assign ctrl.load = rdy[NUM_STAGES-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = valid[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          valid[i] <= feed[i];
        end
      end
    end
  end

endmodule

@@ hdl/hcp_basis.sv @@
// Powers of t and the four Hermite basis weights, three register stages.
module hcp_basis #(
  parameter int T_FRAC_BITS = hcp_pkg::T_FRAC_BITS_DEF,
  parameter int HW          = T_FRAC_BITS + 4
) (
  input  logic                      clk,
  input  hcp_pkg::pipe_ctrl_t       ctrl,
  input  logic [T_FRAC_BITS:0]      t_param,
  output logic signed [HW-1:0]      h [hcp_pkg::NUM_TERMS]
);
  import hcp_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic [TW-1:0]   t_clamp;
  logic [2*TW-1:0] sq_full;
  logic [2*TW-1:0] cube_full;

  logic [TW-1:0] t1, q1;
  logic [TW-1:0] t2, q2, c2;

  logic signed [HW-1:0] s_e, q_e, c_e, one_e;
  logic signed [HW-1:0] h_next [NUM_TERMS];

  // values above 1.0 evaluate at 1.0
  assign t_clamp  = (t_param > T_ONE) ? T_ONE : t_param;
  assign sq_full  = {{TW{1'b0}}, t_clamp} * {{TW{1'b0}}, t_clamp};

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_SQUARE]) begin
      t1 <= t_clamp;
      q1 <= sq_full[T_FRAC_BITS +: TW];
    end
  end

  assign cube_full = {{TW{1'b0}}, q1} * {{TW{1'b0}}, t1};

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_CUBE]) begin
      t2 <= t1;
      q2 <= q1;
      c2 <= cube_full[T_FRAC_BITS +: TW];
    end
  end

  assign s_e   = signed'({3'b000, t2});
  assign q_e   = signed'({3'b000, q2});
  assign c_e   = signed'({3'b000, c2});
  assign one_e = signed'({3'b000, T_ONE});

  always_comb begin
    h_next[TERM_START]     = (c_e <<< 1) - (q_e + (q_e <<< 1)) + one_e;
    h_next[TERM_END]       = (q_e + (q_e <<< 1)) - (c_e <<< 1);
    h_next[TERM_START_TAN] = c_e - (q_e <<< 1) + s_e;
    h_next[TERM_END_TAN]   = c_e - q_e;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_WEIGHT]) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        h[k] <= h_next[k];
      end
    end
  end

endmodule

@@ hdl/hcp_axis.sv @@
// One coordinate: weighted products, sum, truncate toward zero, saturate.
module hcp_axis #(
  parameter int T_FRAC_BITS = hcp_pkg::T_FRAC_BITS_DEF,
  parameter int COORD_WIDTH = hcp_pkg::COORD_WIDTH_DEF,
  parameter int HW          = T_FRAC_BITS + 4
) (
  input  logic                        clk,
  input  hcp_pkg::pipe_ctrl_t         ctrl,
  input  logic signed [HW-1:0]        h    [hcp_pkg::NUM_TERMS],
  input  logic signed [COORD_WIDTH-1:0] coef [hcp_pkg::NUM_TERMS],
  output logic signed [COORD_WIDTH-1:0] coord,
  output logic                        clip
);
  import hcp_pkg::*;

  localparam int PW = HW + COORD_WIDTH;
  localparam int SW = PW + 2;
  localparam int QW = SW - T_FRAC_BITS;

  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] hx [NUM_TERMS];
  logic signed [PW-1:0] cx [NUM_TERMS];
  logic signed [PW-1:0] prod [NUM_TERMS];
  logic signed [SW-1:0] sum_next;
  logic signed [SW-1:0] sum;
  logic signed [QW-1:0] quo;
  logic signed [QW-1:0] quo_fix;
  logic                 in_range;
  logic signed [COORD_WIDTH-1:0] coord_next;

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      hx[k] = PW'(h[k]);
      cx[k] = PW'(coef[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_PROD]) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        prod[k] <= hx[k] * cx[k];
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      sum_next = sum_next + SW'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_SUM]) begin
      sum <= sum_next;
    end
  end

  // floor shift, then bump negatives with a nonzero fraction toward zero
  assign quo     = sum[SW-1:T_FRAC_BITS];
  assign quo_fix = (sum[SW-1] && (|sum[T_FRAC_BITS-1:0])) ? quo + QW'(1) : quo;

  assign in_range = (&quo_fix[QW-1:COORD_WIDTH-1]) || !(|quo_fix[QW-1:COORD_WIDTH-1]);

  always_comb begin
    if (in_range) begin
      coord_next = quo_fix[COORD_WIDTH-1:0];
    end else if (quo_fix[QW-1]) begin
      coord_next = C_MIN;
    end else begin
      coord_next = C_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[ST_OUT]) begin
      coord <= coord_next;
      clip  <= !in_range;
    end
  end

endmodule

@@ hdl/hermite_curve_point_core.sv @@
// Top level of the 2-D cubic Hermite curve point evaluator.
//
// Usage: load the start point, end point and both tangents through the cfg
// channel (cfg_index picks the register, cfg_data carries the value; indexes
// past the last register are dropped). cfg_ready is always high. Then send
// t_param beats (unsigned, T_FRAC_BITS fraction bits; anything above 1.0 is
// treated as 1.0). Each input beat yields one output beat carrying px, py and
// clipped, which is set when either coordinate saturated.
// Six register stages. Throughput: one beat per cycle while out_ready is
// high, with the multipliers spread over separate stages (square, cube,
// products).
// Reset clears all coordinate registers to zero and empties the pipeline.
// When out_ready is low, stages fill from the output end backward; in_ready
// drops only once every stage holds a beat, and nothing is lost or repeated.
module hermite_curve_point_core #(
  parameter int T_FRAC_BITS = hcp_pkg::T_FRAC_BITS_DEF,
  parameter int COORD_WIDTH = hcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hcp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [T_FRAC_BITS:0]                t_param,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       px,
  output logic signed [COORD_WIDTH-1:0]       py,
  output logic                                clipped
);
  import hcp_pkg::*;

  localparam int HW = T_FRAC_BITS + 4;

  pipe_ctrl_t ctrl;

  logic signed [COORD_WIDTH-1:0] start_x, start_y, end_x, end_y;
  logic signed [COORD_WIDTH-1:0] start_tan_x, start_tan_y, end_tan_x, end_tan_y;
  logic signed [COORD_WIDTH-1:0] coef_x [NUM_TERMS];
  logic signed [COORD_WIDTH-1:0] coef_y [NUM_TERMS];
  logic signed [HW-1:0]          h [NUM_TERMS];
  logic                          clip_x, clip_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= '0;
      end_y       <= '0;
      start_tan_x <= '0;
      start_tan_y <= '0;
      end_tan_x   <= '0;
      end_tan_y   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_X:     start_x     <= cfg_data;
        REG_START_Y:     start_y     <= cfg_data;
        REG_END_X:       end_x       <= cfg_data;
        REG_END_Y:       end_y       <= cfg_data;
        REG_START_TAN_X: start_tan_x <= cfg_data;
        REG_START_TAN_Y: start_tan_y <= cfg_data;
        REG_END_TAN_X:   end_tan_x   <= cfg_data;
        REG_END_TAN_Y:   end_tan_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef_x[TERM_START]     = start_x;
    coef_x[TERM_END]       = end_x;
    coef_x[TERM_START_TAN] = start_tan_x;
    coef_x[TERM_END_TAN]   = end_tan_x;
    coef_y[TERM_START]     = start_y;
    coef_y[TERM_END]       = end_y;
    coef_y[TERM_START_TAN] = start_tan_y;
    coef_y[TERM_END_TAN]   = end_tan_y;
  end

  hcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  hcp_basis #(
    .T_FRAC_BITS (T_FRAC_BITS),
    .HW          (HW)
  ) u_basis (
    .clk     (clk),
    .ctrl    (ctrl),
    .t_param (t_param),
    .h       (h)
  );

  hcp_axis #(
    .T_FRAC_BITS (T_FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH),
    .HW          (HW)
  ) u_axis_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .h     (h),
    .coef  (coef_x),
    .coord (px),
    .clip  (clip_x)
  );

  hcp_axis #(
    .T_FRAC_BITS (T_FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH),
    .HW          (HW)
  ) u_axis_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .h     (h),
    .coef  (coef_y),
    .coord (py),
    .clip  (clip_y)
  );

  assign clipped = clip_x | clip_y;

endmodule

@@ tb/hermite_curve_point_core_tb.sv @@
// Self-checking testbench for the Hermite curve point core: scoreboard, stimulus and checks.
module hermite_curve_point_core_tb;
  import hcp_pkg::*;

  localparam int TFB = T_FRAC_BITS_DEF;
  localparam int CW = COORD_WIDTH_DEF;
  localparam int PARAM_W = TFB + 1;
  localparam longint T_ONE = longint'(1) << TFB;
  localparam int unsigned PARAM_ONE = 1 << TFB;
  localparam int unsigned PARAM_TOP = (1 << (TFB + 1)) - 1;
  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int PIPE_LATENCY = 6;
  localparam int HOLD_CYCLES = 60;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 56;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 clipped;
  } curve_point_t;

  class curve_scoreboard;
    logic signed [CW-1:0] coord_reg [1 << CFG_INDEX_WIDTH];
    curve_point_t         pending_points[$];
    int                   mismatches;

    function new();
      foreach (coord_reg[i]) coord_reg[i] = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
      if (idx <= REG_END_TAN_Y) coord_reg[idx] = val;
    endfunction

    // drop the fraction (toward zero), then clamp to the coordinate range
    function logic signed [CW-1:0] saturate(longint acc, inout bit clip);
      longint hi, lo, v;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      v = acc / T_ONE;
      if (v > hi) begin
        v = hi;
        clip = 1'b1;
      end
      if (v < lo) begin
        v = lo;
        clip = 1'b1;
      end
      return v[CW-1:0];
    endfunction

    function void note_param(logic [TFB:0] t_raw);
      longint t, t2, t3, h1, h2, h3, h4, acc_x, acc_y;
      bit clip;
      curve_point_t pt;
      t = longint'(t_raw);
      if (t > T_ONE) t = T_ONE;
      t2 = (t * t) >> TFB;
      t3 = (t2 * t) >> TFB;
      h1 = 2 * t3 - 3 * t2 + T_ONE;
      h2 = 3 * t2 - 2 * t3;
      h3 = t3 - 2 * t2 + t;
      h4 = t3 - t2;
      acc_x = h1 * coord_reg[REG_START_X] + h2 * coord_reg[REG_END_X]
            + h3 * coord_reg[REG_START_TAN_X] + h4 * coord_reg[REG_END_TAN_X];
      acc_y = h1 * coord_reg[REG_START_Y] + h2 * coord_reg[REG_END_Y]
            + h3 * coord_reg[REG_START_TAN_Y] + h4 * coord_reg[REG_END_TAN_Y];
      clip = 1'b0;
      pt.px = saturate(acc_x, clip);
      pt.py = saturate(acc_y, clip);
      pt.clipped = clip;
      pending_points.push_back(pt);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_point(logic [CW-1:0] px, logic [CW-1:0] py, logic clipped);
      curve_point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point px=%0d py=%0d clipped=%0b",
                                  $signed(px), $signed(py), clipped));
        return;
      end
      want = pending_points.pop_front();
      if (px !== want.px)
        report_mismatch($sformatf("px got %0d want %0d", $signed(px), want.px));
      if (py !== want.py)
        report_mismatch($sformatf("py got %0d want %0d", $signed(py), want.py));
      if (clipped !== want.clipped)
        report_mismatch($sformatf("clipped got %b want %b", clipped, want.clipped));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TFB:0] t_param = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic clipped;

  curve_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;

  logic [TFB:0] corner_params[12] = '{
    17'h00000, 17'h00001, 17'h00002, 17'h04000, 17'h08000, 17'h0C000,
    17'h0FFFF, 17'h10000, 17'h10001, 17'h1FFFF, 17'h15555, 17'h0AAAA
  };

  hermite_curve_point_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .t_param   (t_param),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .px        (px),
    .py        (py),
    .clipped   (clipped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_point(px, py, clipped);
  end

  task automatic send_param(logic [TFB:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    t_param <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_param(v);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.load_reg(idx, val);
  endtask

  // stop offering beats until every expected point is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // kind 0: extremes, 1: small values, 2: full range, 3: mix per register
  task automatic program_curve(int kind);
    int sel;
    logic [CW-1:0] val;
    for (int i = REG_START_X; i <= REG_END_TAN_Y; i++) begin
      sel = (kind == 3) ? $urandom_range(2) : kind;
      case (sel)
        0: val = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        1: val = CW'($urandom_range(4000) - 2000);
        default: val = CW'($urandom);
      endcase
      write_cfg(CFG_INDEX_WIDTH'(i), val);
      // writes past the last register must leave the curve alone
      if (i == REG_END_Y)
        write_cfg(CFG_INDEX_WIDTH'($urandom_range(15, REG_END_TAN_Y + 1)), CW'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TFB:0] v;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset state: all registers zero
    send_param(17'h08000);
    drain();

    // every register at its upper limit: clips mid-curve
    for (int i = REG_START_X; i <= REG_END_TAN_Y; i++) write_cfg(CFG_INDEX_WIDTH'(i), COORD_MAX);
    cfg_valid <= 1'b0;
    foreach (corner_params[i]) send_param(corner_params[i]);
    drain();

    // opposing extremes, y pushed below the lower limit
    write_cfg(REG_START_X, COORD_MAX);
    write_cfg(REG_END_X, COORD_MIN);
    write_cfg(REG_START_TAN_X, COORD_MAX);
    write_cfg(REG_END_TAN_X, COORD_MIN);
    write_cfg(REG_START_Y, COORD_MIN);
    write_cfg(REG_END_Y, COORD_MIN);
    write_cfg(REG_START_TAN_Y, COORD_MIN);
    write_cfg(REG_END_TAN_Y, COORD_MAX);
    cfg_valid <= 1'b0;
    foreach (corner_params[i]) send_param(corner_params[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      program_curve((p + p / 4) % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 20 && p % 8 == 0) holds_asked++;
        if (n == 35 && p % 3 == 1) drain();
        case ($urandom_range(9))
          0: v = PARAM_W'($urandom_range(PARAM_TOP, PARAM_ONE + 1));
          1: v = PARAM_W'(PARAM_ONE);
          default: v = PARAM_W'($urandom_range(PARAM_ONE, 0));
        endcase
        send_param(v);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
